[hw/rtl/qsbe_pkg.sv]
// ----------------------------------------------------------------------------
// qsbe_pkg
// Types and constants shared by the billboard quad expansion block.
// ----------------------------------------------------------------------------
package qsbe_pkg;

    localparam int VERTEX_INDEX_BITS_DEFAULT = 16;
    localparam int NUM_AXES                  = 6;
    localparam int CFG_INDEX_W               = 3;

    // 1/sqrt2 in Q1.30.
    localparam logic [31:0] INV_SQRT2_Q30 = 32'd759250125;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_Z = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UP_X   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UP_Y   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UP_Z   = 3'd5;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               batch_start;
        logic        [15:0] batch_vertex_count;
        logic        [16:0] batch_index_count;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               tex_s;
        logic               tex_t;
        logic        [15:0] vertex_number;
        logic               tri_valid;
        logic        [15:0] tri_index_a;
        logic        [15:0] tri_index_b;
        logic        [15:0] tri_index_c;
        logic               rejected;
        logic               quad_last;
    } out_t;

    typedef logic signed [NUM_AXES-1:0][15:0] axis_t;

    // One request from the front to the back: a rejected vertex or a whole quad.
    typedef struct packed {
        logic                   is_quad;
        logic signed [2:0][31:0] centre;   // pass-through position when rejected
        logic signed [2:0][31:0] corner0;
        logic        [15:0]      vnum;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/qsbe_front.sv]
// ----------------------------------------------------------------------------
// qsbe_front
// Accepts vertices, tracks batch checks and quad slots, stores corners 0 to 2
// and forms a request for each rejected vertex and each completed quad.
// ----------------------------------------------------------------------------
module qsbe_front
    import qsbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_t       item,
    output logic      push,
    output job_t      job
);

    logic [1:0]  slot_reg, slot_next;
    logic [15:0] count_reg, count_next;
    logic        bad_reg, bad_next;
    logic signed [2:0][31:0] c0_reg, c1_reg, c2_reg;

    logic        eff_bad;
    logic [1:0]  eff_slot;
    logic [15:0] vnum;
    logic [16:0] want_ic;
    logic signed [2:0][31:0] pos;
    logic signed [2:0][31:0] centre;
    logic signed [33:0] sum [3];

    assign pos[0] = item.pos_x;
    assign pos[1] = item.pos_y;
    assign pos[2] = item.pos_z;

    always_comb
    begin
        want_ic  = {1'b0, item.batch_vertex_count[15:2], 2'b00}
                 + {2'b00, item.batch_vertex_count[15:2], 1'b0};
        eff_bad  = item.batch_start ? ((item.batch_vertex_count[1:0] != 2'd0)
                                       || (item.batch_index_count != want_ic))
                                    : bad_reg;
        eff_slot = item.batch_start ? 2'd0 : slot_reg;
        vnum     = item.batch_start ? 16'd0 : count_reg;
        for (int j = 0; j < 3; j++)
        begin
            // Elements of a packed array are unsigned, so sign-extend explicitly.
            sum[j]    = 34'($signed(c0_reg[j])) + 34'($signed(c1_reg[j]))
                      + 34'($signed(c2_reg[j])) + 34'($signed(pos[j]));
            centre[j] = sum[j][33:2];
        end
    end

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        push       = 1'b0;
        job.is_quad = 1'b0;
        job.centre  = pos;
        job.corner0 = c0_reg;
        job.vnum    = vnum;
        if (accept)
        begin
            bad_next   = eff_bad;
            count_next = vnum + 16'd1;
            slot_next  = eff_slot;
            if (eff_bad)
            begin
                push = 1'b1;
            end
            else if (eff_slot == 2'd3)
            begin
                push        = 1'b1;
                job.is_quad = 1'b1;
                job.centre  = centre;
                slot_next   = 2'd0;
            end
            else
            begin
                slot_next = eff_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 2'd0;
            count_reg <= 16'd0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !eff_bad)
        begin
            if (eff_slot == 2'd0) c0_reg <= pos;
            if (eff_slot == 2'd1) c1_reg <= pos;
            if (eff_slot == 2'd2) c2_reg <= pos;
        end
    end

endmodule

[hw/rtl/qsbe_queue.sv]
// ----------------------------------------------------------------------------
// qsbe_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module qsbe_queue
    import qsbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      wr_job,
    input  logic      pop,
    output job_t      rd_job,
    output q_status_t status
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;

    assign rd_job       = mem_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == 2'd2);
    assign status.empty = (fill_reg == 2'd0);

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

[hw/rtl/qsbe_back.sv]
// ----------------------------------------------------------------------------
// qsbe_back
// Rebuilds each quad as a camera-facing square: squared distance, bit-pair
// square root, radius scaling, axis terms, then four corner results.
// ----------------------------------------------------------------------------
module qsbe_back
    import qsbe_pkg::*;
#(
    parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  axis_t axis,
    input  logic  job_avail,
    input  job_t  job,
    output logic  pop,
    output logic  out_valid,
    input  logic  out_stall,
    output out_t  out_data
);

    localparam int IDX_W = (VERTEX_INDEX_BITS < 16) ? VERTEX_INDEX_BITS : 16;
    localparam logic [16:0] IDX_MASK = 17'((18'd1 << IDX_W) - 18'd1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_SQ   = 7'b0000100,
        ST_ROOT = 7'b0001000,
        ST_RAD  = 7'b0010000,
        ST_AXIS = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    job_t        job_reg;
    logic signed [31:0] delta_reg [3];
    logic [63:0] sq_prod_reg, acc_reg, nsh_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] rad_prod_reg;
    logic [31:0] radius_reg;
    logic signed [48:0] ax_prod_reg;
    logic signed [34:0] term_reg [6];
    logic        out_valid_reg;
    out_t        out_reg, result;

    logic [35:0] rem_t, trial;
    logic        fire;
    logic [2:0]  term_idx;
    logic signed [32:0] diff [3];
    logic signed [31:0] dsat [3];
    logic signed [48:0] ax_round;
    logic signed [34:0] lsum [3];
    logic [15:0] base;
    logic [16:0] idx_a, idx_b, idx_c;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = (state_reg == ST_IDLE) && job_avail;
    assign fire      = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign rem_t     = {rem_reg, nsh_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign term_idx  = cnt_reg[2:0] - 3'd1;
    assign ax_round  = ax_prod_reg + 49'sd8192;
    assign base      = job_reg.vnum - 16'd3;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            diff[j] = 33'($signed(job_reg.centre[j])) - 33'($signed(job_reg.corner0[j]));
            if (diff[j] > 33'sd2147483647)
                dsat[j] = 32'sh7fffffff;
            else if (diff[j] < -33'sd2147483648)
                dsat[j] = 32'sh80000000;
            else
                dsat[j] = diff[j][31:0];
        end
    end

    // Result of the current corner; the rejected case passes the vertex on.
    always_comb
    begin
        result = '0;
        idx_a  = '0;
        idx_b  = '0;
        idx_c  = '0;
        for (int j = 0; j < 3; j++)
            lsum[j] = '0;
        if (!job_reg.is_quad)
        begin
            result.out_x         = job_reg.centre[0];
            result.out_y         = job_reg.centre[1];
            result.out_z         = job_reg.centre[2];
            result.vertex_number = job_reg.vnum;
            result.rejected      = 1'b1;
            result.quad_last     = 1'b1;
        end
        else
        begin
            for (int j = 0; j < 3; j++)
            begin
                lsum[j] = 35'($signed(job_reg.centre[j]))
                        + ((cnt_reg[1:0] == 2'd0 || cnt_reg[1:0] == 2'd3)
                           ? term_reg[j] : -term_reg[j])
                        + ((cnt_reg[1:0] == 2'd0 || cnt_reg[1:0] == 2'd1)
                           ? term_reg[3+j] : -term_reg[3+j]);
                if (lsum[j] > 35'sd2147483647)
                    lsum[j] = 35'sd2147483647;
                else if (lsum[j] < -35'sd2147483648)
                    lsum[j] = -35'sd2147483648;
            end
            result.out_x         = lsum[0][31:0];
            result.out_y         = lsum[1][31:0];
            result.out_z         = lsum[2][31:0];
            result.tex_s         = (cnt_reg[1:0] == 2'd1) || (cnt_reg[1:0] == 2'd2);
            result.tex_t         = cnt_reg[1];
            result.vertex_number = base + 16'(cnt_reg[1:0]);
            result.quad_last     = (cnt_reg[1:0] == 2'd3);
            if (cnt_reg[1:0] == 2'd0)
            begin
                idx_a = 17'(base);
                idx_b = 17'(base) + 17'd1;
                idx_c = 17'(base) + 17'd3;
            end
            else if (cnt_reg[1:0] == 2'd1)
            begin
                idx_a = 17'(base) + 17'd3;
                idx_b = 17'(base) + 17'd1;
                idx_c = 17'(base) + 17'd2;
            end
            result.tri_valid   = !cnt_reg[1];
            result.tri_index_a = 16'(idx_a & IDX_MASK);
            result.tri_index_b = 16'(idx_b & IDX_MASK);
            result.tri_index_c = 16'(idx_c & IDX_MASK);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 5'd0;
                if (job_avail)
                    state_next = job.is_quad ? ST_LOAD : ST_EMIT;
            end
            ST_LOAD:
            begin
                cnt_next   = 5'd0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == 5'd31)
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_RAD;
                end
            end
            ST_RAD:
            begin
                if (cnt_reg == 5'd1)
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                if (cnt_reg == 5'd6)
                begin
                    cnt_next   = 5'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cnt_next = cnt_reg;
                if (fire)
                begin
                    cnt_next = cnt_reg + 5'd1;
                    if (!job_reg.is_quad || cnt_reg == 5'd3)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = 5'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) job_reg <= job;
        if (fire) out_reg <= result;
        case (state_reg)
            ST_LOAD:
            begin
                for (int j = 0; j < 3; j++)
                    delta_reg[j] <= dsat[j];
                acc_reg <= 64'd0;
            end
            ST_SQ:
            begin
                if (cnt_reg < 5'd3)
                    sq_prod_reg <= 64'(delta_reg[cnt_reg[1:0]] * delta_reg[cnt_reg[1:0]]);
                if (cnt_reg > 5'd0)
                    acc_reg <= acc_reg + sq_prod_reg;
                if (cnt_reg == 5'd3)
                begin
                    nsh_reg  <= acc_reg + sq_prod_reg;
                    rem_reg  <= 34'd0;
                    root_reg <= 32'd0;
                end
            end
            ST_ROOT:
            begin
                // One result bit per cycle, two radicand bits brought down.
                if (rem_t >= trial)
                begin
                    rem_reg  <= 34'(rem_t - trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                nsh_reg <= {nsh_reg[61:0], 2'b00};
            end
            ST_RAD:
            begin
                if (cnt_reg == 5'd0)
                    rad_prod_reg <= 64'(root_reg) * 64'(INV_SQRT2_Q30);
                else
                    radius_reg <= 32'((rad_prod_reg + 64'd536870912) >> 30);
            end
            ST_AXIS:
            begin
                if (cnt_reg < 5'd6)
                    ax_prod_reg <= 49'($signed({1'b0, radius_reg})
                                       * $signed(axis[cnt_reg[2:0]]));
                if (cnt_reg > 5'd0)
                    term_reg[term_idx] <= 35'(ax_round >>> 14);
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/quad_sprite_billboard_expand.sv]
// ----------------------------------------------------------------------------
// quad_sprite_billboard_expand
// Groups vertices into quads and rebuilds each as a camera-facing square.
// ----------------------------------------------------------------------------
// Corners 0 to 2 are stored in the front and give no result; a rejected
// vertex gives a single result, passed on through the queue and back end.
// A quad passes the back end's 32-step square root and then gives four
// results, held while out_stall is high; a 2-deep queue lets the
// front take further vertices meanwhile. Reset clears all control state and
// the axis registers; no clearing pass is needed.
module quad_sprite_billboard_expand
    import qsbe_pkg::*;
#(
    parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_t                   out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    axis_t     axis_reg;
    q_status_t q_status;
    job_t      push_job, pop_job;
    logic      push, pop, accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axis_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_X: axis_reg[0] <= cfg_data;
                REG_LEFT_Y: axis_reg[1] <= cfg_data;
                REG_LEFT_Z: axis_reg[2] <= cfg_data;
                REG_UP_X:   axis_reg[3] <= cfg_data;
                REG_UP_Y:   axis_reg[4] <= cfg_data;
                REG_UP_Z:   axis_reg[5] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    qsbe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .push   (push),
        .job    (push_job)
    );

    qsbe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .pop    (pop),
        .rd_job (pop_job),
        .status (q_status)
    );

    qsbe_back #(
        .VERTEX_INDEX_BITS (VERTEX_INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (axis_reg),
        .job_avail (!q_status.empty),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // A rejected vertex is always the only and last result of its input.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rejected |-> out_data.quad_last && !out_data.tri_valid)
        else $error("rejected result without quad_last");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("request pushed into a full queue");

    // A pop always leaves room in the queue on the next cycle.
    a_last_then_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !q_status.full)
        else $error("queue still full after a pop");
`endif

endmodule
